// ----- rtl/core/bdsi_pkg.sv -----
// Package for the radix digit string to integer core.
// Holds widths, character codes, the reset base and the digit decode function.
// Depends on nothing; every other file of the block uses it.
package bdsi_pkg;

	localparam int CHAR_W  = 8;
	localparam int RADIX_W = 7;
	localparam int VALUE_W = 64;
	localparam int DIGIT_W = 6;

	localparam logic [RADIX_W-1:0] RADIX_RESET   = 7'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN     = 7'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX     = 7'd64;
	localparam logic [RADIX_W-1:0] RADIX_ALNUM   = 7'd36;
	localparam logic [RADIX_W-1:0] RADIX_NOCASE  = 7'd38;

	localparam logic [CHAR_W-1:0] CH_DOT     = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CH_NINE    = 8'h39;
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
	localparam logic [CHAR_W-1:0] CH_UPPER_Z = 8'h5A;
	localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;

	// Offsets that close the gaps between the digit, upper and lower ranges.
	localparam logic signed [9:0] GAP_UPPER = 10'(int'(CH_UPPER_A) - int'(CH_NINE) - 1);
	localparam logic signed [9:0] GAP_LOWER_NOCASE = 10'(int'(CH_LOWER_A) - int'(CH_NINE) - 1);
	localparam logic signed [9:0] GAP_LOWER_CASE = 10'((int'(CH_LOWER_A) - int'(CH_UPPER_Z) - 1)
		+ (int'(CH_UPPER_A) - int'(CH_NINE) - 1));

	typedef struct packed {
		logic               ok;
		logic [DIGIT_W-1:0] digit;
	} digit_t;

	// Decodes one character into its digit value in base b.
	function automatic digit_t digit_of(input logic [CHAR_W-1:0] ch,
		input logic [RADIX_W-1:0] b);
		logic signed [9:0] c;
		logic              dead;
		digit_t            r;
		c    = signed'({2'b00, ch});
		dead = 1'b0;
		if (ch >= CH_LOWER_A) begin
			if (b <= RADIX_NOCASE) begin
				c = c - GAP_LOWER_NOCASE;
			end else begin
				c = c - GAP_LOWER_CASE;
			end
		end else if (ch > CH_UPPER_Z) begin
			dead = 1'b1;
		end else if (ch >= CH_UPPER_A) begin
			c = c - GAP_UPPER;
		end else if (ch > CH_NINE) begin
			dead = 1'b1;
		end
		if (b > RADIX_ALNUM) begin
			c = c - signed'({2'b00, CH_DOT});
		end else begin
			c = c - signed'({2'b00, CH_ZERO});
		end
		r.ok    = !dead && (c >= 10'sd0) && (c < signed'({3'b000, b}));
		r.digit = c[DIGIT_W-1:0];
		return r;
	endfunction

endpackage

// ----- rtl/core/bdsi_in_if.sv -----
// Input channel of the digit string core: one character beat per transfer.
// Depends on bdsi_pkg for the field widths.
interface bdsi_in_if;
	logic                          valid;
	logic                          ready;
	logic [bdsi_pkg::CHAR_W-1:0]   char_code;
	logic                          last_char;

	modport source (output valid, output char_code, output last_char, input ready);
	modport sink (input valid, input char_code, input last_char, output ready);
endinterface

// ----- rtl/core/bdsi_out_if.sv -----
// Output channel of the digit string core: one result beat per string.
// Depends on bdsi_pkg for the field widths.
interface bdsi_out_if;
	logic                          valid;
	logic                          ready;
	logic [bdsi_pkg::VALUE_W-1:0]  value;
	logic                          bad_digit;
	logic                          too_large;

	modport source (output valid, output value, output bad_digit, output too_large,
		input ready);
	modport sink (input valid, input value, input bad_digit, input too_large,
		output ready);
endinterface

// ----- rtl/core/base_digit_string_to_integer_core.sv -----
// Radix digit string to unsigned 64-bit integer, one character beat per cycle unless the result register stalls.
// A result beat is registered in the result register when the last character leaves the input register.
// The 64x7 multiply-add and overflow check update the accumulator combinationally
// from the input register.
// Reset (arst_n low, asynchronous) sets the base to 10, clears the accumulator,
// both sticky flags and all valid bits; no clearing pass is needed.
module base_digit_string_to_integer_core (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_wr_en,
	input  logic [bdsi_pkg::RADIX_W-1:0]  cfg_wr_data,
	bdsi_in_if.sink                       in_chan,
	bdsi_out_if.source                    out_chan
);

	localparam int PROD_W = bdsi_pkg::VALUE_W + bdsi_pkg::RADIX_W;

	logic [bdsi_pkg::RADIX_W-1:0] radix_q;

	logic                         valid_s1;
	logic [bdsi_pkg::CHAR_W-1:0]  char_s1;
	logic                         last_s1;

	logic [bdsi_pkg::VALUE_W-1:0] acc_q;
	logic                         err_q;
	logic                         ovf_q;

	logic                         out_valid_q;
	logic [bdsi_pkg::VALUE_W-1:0] out_value_q;
	logic                         out_bad_q;
	logic                         out_large_q;

	logic                         advance;
	logic                         bad_base;
	bdsi_pkg::digit_t             dig;
	logic [PROD_W-1:0]            prod;
	logic [bdsi_pkg::VALUE_W:0]   sum;
	logic                         wrap;
	logic [bdsi_pkg::VALUE_W-1:0] acc_n;
	logic                         err_n;
	logic                         ovf_n;

	// The stage moves on whenever the result register is free or being drained.
	assign advance       = valid_s1 && (!out_valid_q || out_chan.ready);
	assign in_chan.ready = !valid_s1 || advance;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= bdsi_pkg::RADIX_RESET;
		end else if (cfg_wr_en) begin
			radix_q <= cfg_wr_data;
		end
	end

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_chan.ready) begin
			valid_s1 <= in_chan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_chan.ready && in_chan.valid) begin
			char_s1 <= in_chan.char_code;
			last_s1 <= in_chan.last_char;
		end
	end

	// Digit decode, multiply-add and overflow detection.
	always_comb begin
		bad_base = (radix_q < bdsi_pkg::RADIX_MIN) || (radix_q > bdsi_pkg::RADIX_MAX);
		dig      = bdsi_pkg::digit_of(char_s1, radix_q);
		prod     = acc_q * {{bdsi_pkg::VALUE_W{1'b0}}, radix_q};
		sum      = {1'b0, prod[bdsi_pkg::VALUE_W-1:0]}
			+ {{(bdsi_pkg::VALUE_W + 1 - bdsi_pkg::DIGIT_W){1'b0}}, dig.digit};
		wrap     = (|prod[PROD_W-1:bdsi_pkg::VALUE_W]) || sum[bdsi_pkg::VALUE_W];
		acc_n    = acc_q;
		err_n    = err_q;
		ovf_n    = ovf_q;
		if (!err_q && !ovf_q) begin
			if (bad_base || !dig.ok) begin
				err_n = 1'b1;
			end else if (wrap) begin
				ovf_n = 1'b1;
			end else begin
				acc_n = sum[bdsi_pkg::VALUE_W-1:0];
			end
		end
	end

	// Accumulator and sticky flags; cleared after the last character.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			err_q <= 1'b0;
			ovf_q <= 1'b0;
		end else if (advance) begin
			if (last_s1) begin
				acc_q <= '0;
				err_q <= 1'b0;
				ovf_q <= 1'b0;
			end else begin
				acc_q <= acc_n;
				err_q <= err_n;
				ovf_q <= ovf_n;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (out_chan.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_value_q <= (err_n || ovf_n) ? '0 : acc_n;
			out_bad_q   <= err_n;
			out_large_q <= ovf_n;
		end
	end

	assign out_chan.valid     = out_valid_q;
	assign out_chan.value     = out_value_q;
	assign out_chan.bad_digit = out_bad_q;
	assign out_chan.too_large = out_large_q;

	// The first fault wins, so the two sticky flags never stand together.
	assert property (@(posedge clk) disable iff (!arst_n) !(err_q && ovf_q))
		else $error("both sticky flags set");

	// A faulted string always reports a zero value.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_bad_q || out_large_q) |-> out_value_q == '0)
		else $error("faulted result carries a nonzero value");

	// A stalled character stays in the input register unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(char_s1) && $stable(last_s1))
		else $error("stalled character lost");

	// State is clear once a last character has been consumed.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> acc_q == '0 && !err_q && !ovf_q)
		else $error("state not cleared after the last character");

endmodule
